// ===== hdl/bbe_pkg.sv =====
// Shared types and constants of the block bit-packing encoder.
`default_nettype none
package bbe_pkg;

  localparam int unsigned BLOCK_SIZE = 8;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned IDX_W      = $clog2(BLOCK_SIZE);
  localparam int unsigned HDR_W      = 4;
  localparam int unsigned WIDTH_W    = 5;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned PAYLOAD_W  = BLOCK_SIZE * SAMPLE_W;
  localparam int unsigned OUT_DATA_W = 144;

  // Payload byte count of a raw tail item
  localparam logic [WIDTH_W-1:0] RAW_BYTES = WIDTH_W'(SAMPLE_W / 8);
  // Header code that stands for a full 16-bit width
  localparam logic [HDR_W-1:0] HDR_FULL = 4'hF;

  typedef enum logic {
    KIND_BLOCK = 1'b0,
    KIND_RAW   = 1'b1
  } kind_e;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [BLOCK_SIZE-1:0] block_t;

  typedef struct packed {
    kind_e               kind;
    logic [HDR_W-1:0]    hdr;
    logic [HALF_W-1:0]   low;
    logic [HALF_W-1:0]   high;
    logic [WIDTH_W-1:0]  bytes;
    logic                last;
  } res_t;

  // Tail item offered by the gather stage
  typedef struct packed {
    logic    valid;
    sample_t data;
    logic    last;
  } tail_t;

endpackage
`default_nettype wire

// ===== hdl/bbe_gather.sv =====
// Sample buffer, fill counter, zigzag coding of full blocks and tail drain.
`default_nettype none
module bbe_gather (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    accept_i,
  input  wire  bbe_pkg::sample_t sample_i,
  input  wire                    eos_i,
  input  wire                    zig_en_i,
  input  wire                    tail_take_i,
  output logic                   blk_load_o,
  output bbe_pkg::block_t        blk_data_o,
  output logic                   busy_o,
  output bbe_pkg::tail_t         tail_o
);

  bbe_pkg::block_t               buf_q;
  logic [bbe_pkg::IDX_W-1:0]     fill_q, fill_d;
  logic [bbe_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [bbe_pkg::IDX_W-1:0]     last_idx_q, last_idx_d;
  logic                          drain_q, drain_d;
  logic                          full;
  bbe_pkg::block_t               raw_blk;

  assign full = (fill_q == bbe_pkg::IDX_W'(bbe_pkg::BLOCK_SIZE - 1));

  // Store the accepted sample in its slot
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      buf_q[fill_q] <= sample_i;
    end
  end

  // Assemble the full block with the new sample and zigzag code it when enabled
  always_comb begin
    raw_blk = buf_q;
    raw_blk[bbe_pkg::BLOCK_SIZE-1] = sample_i;
    for (int i = 0; i < bbe_pkg::BLOCK_SIZE; i++) begin
      if (zig_en_i) begin
        blk_data_o[i] = {raw_blk[i][bbe_pkg::SAMPLE_W-2:0], 1'b0} ^
                        {bbe_pkg::SAMPLE_W{raw_blk[i][bbe_pkg::SAMPLE_W-1]}};
      end else begin
        blk_data_o[i] = raw_blk[i];
      end
    end
  end

  assign blk_load_o = accept_i && full;

  // Advance fill count and run the tail drain
  always_comb begin
    fill_d     = fill_q;
    idx_d      = idx_q;
    last_idx_d = last_idx_q;
    drain_d    = drain_q;
    if (accept_i) begin
      if (full) begin
        fill_d = '0;
      end else if (eos_i) begin
        fill_d     = '0;
        idx_d      = '0;
        last_idx_d = fill_q;
        drain_d    = 1'b1;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (tail_take_i) begin
      idx_d = idx_q + 1'b1;
      if (idx_q == last_idx_q) begin
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      idx_q      <= '0;
      last_idx_q <= '0;
      drain_q    <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      idx_q      <= idx_d;
      last_idx_q <= last_idx_d;
      drain_q    <= drain_d;
    end
  end

  assign busy_o       = drain_q;
  assign tail_o.valid = drain_q;
  assign tail_o.data  = buf_q[idx_q];
  assign tail_o.last  = (idx_q == last_idx_q);

endmodule
`default_nettype wire

// ===== hdl/bbe_pack.sv =====
// Block register, width search and variable-width packing of one block.
`default_nettype none
module bbe_pack (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    load_i,
  input  wire  bbe_pkg::block_t  blk_i,
  input  wire                    take_i,
  output logic                   valid_o,
  output bbe_pkg::res_t          res_o
);

  bbe_pkg::block_t                 blk_q;
  logic                            valid_q, valid_d;
  bbe_pkg::sample_t                or_all;
  logic [bbe_pkg::WIDTH_W-1:0]     len;
  logic [bbe_pkg::WIDTH_W-1:0]     wid;
  logic [bbe_pkg::PAYLOAD_W-1:0]   payload;

  // Hold the coded block
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      blk_q <= blk_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (take_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Bit length of the largest value equals bit length of the OR of all values
  always_comb begin
    or_all = '0;
    for (int i = 0; i < bbe_pkg::BLOCK_SIZE; i++) begin
      or_all = or_all | blk_q[i];
    end
    len = '0;
    for (int b = 0; b < bbe_pkg::SAMPLE_W; b++) begin
      if (or_all[b]) len = bbe_pkg::WIDTH_W'(b + 1);
    end
    // Raise width 15 to 16
    wid = (len == bbe_pkg::WIDTH_W'(bbe_pkg::SAMPLE_W - 1)) ?
          bbe_pkg::WIDTH_W'(bbe_pkg::SAMPLE_W) : len;
  end

  // Pack element i at bit i*width, one fixed wiring per width
  always_comb begin
    payload = '0;
    for (int w = 1; w <= bbe_pkg::SAMPLE_W; w++) begin
      if (wid == bbe_pkg::WIDTH_W'(w)) begin
        for (int i = 0; i < bbe_pkg::BLOCK_SIZE; i++) begin
          for (int b = 0; b < w; b++) begin
            payload[i*w + b] = blk_q[i][b];
          end
        end
      end
    end
  end

  assign valid_o     = valid_q;
  assign res_o.kind  = bbe_pkg::KIND_BLOCK;
  assign res_o.hdr   = (wid == bbe_pkg::WIDTH_W'(bbe_pkg::SAMPLE_W)) ?
                       bbe_pkg::HDR_FULL : wid[bbe_pkg::HDR_W-1:0];
  assign res_o.low   = payload[bbe_pkg::HALF_W-1:0];
  assign res_o.high  = payload[bbe_pkg::PAYLOAD_W-1:bbe_pkg::HALF_W];
  assign res_o.bytes = wid;
  assign res_o.last  = 1'b1;

endmodule
`default_nettype wire

// ===== hdl/block_bitpack_encoder.sv =====
// Top level of the block bit-packing encoder: handshakes and result register.
//
//  channel   direction  handshake               content
//  s_axis    in         tvalid/tready           one sample, tlast = end of stream
//  m_axis    out        tvalid/tready           packed block or raw tail sample
//  cfg       in         cfg_we_i                zigzag enable, no read-back
//
// One sample is taken per cycle while s_axis_tready is high. From its eighth
// sample, a full block passes the block register and then the result register.
// An end of stream on a partial block drains the buffer while s_axis_tready is
// low, one raw item per cycle unless m_axis stalls, read from one buffer slot.
// Reset clears the fill count, the drain and all valid flags; zigzag is on.
// A stalled m_axis holds the result register and backs up into s_axis_tready.
`default_nettype none
module block_bitpack_encoder (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [15:0]  s_axis_tdata,   // [15:0] sample
  input  wire          s_axis_tlast,   // end_of_stream
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [143:0] m_axis_tdata,   // [3:0] header_code, [67:4] payload_low,
                                       // [131:68] payload_high,
                                       // [136:132] payload_bytes, rest zero
  output logic         m_axis_tuser,   // item_kind
  output logic         m_axis_tlast,   // last_of_run
  input  wire          cfg_we_i,
  input  wire          cfg_wdata_i     // zigzag_enable
);

  logic                 zig_q;
  logic                 in_acc;
  logic                 out_free;
  logic                 blk_load;
  bbe_pkg::block_t      blk_data;
  logic                 busy;
  bbe_pkg::tail_t       tail;
  logic                 tail_take;
  logic                 pack_valid;
  logic                 pack_take;
  bbe_pkg::res_t        pack_res;
  bbe_pkg::res_t        tail_res;
  bbe_pkg::res_t        res_q, res_d;
  logic                 out_v_q, out_v_d;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zig_q <= 1'b1;
    end else if (cfg_we_i) begin
      zig_q <= cfg_wdata_i;
    end
  end

  assign out_free      = !out_v_q || m_axis_tready;
  assign s_axis_tready = !busy && (!pack_valid || out_free);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  bbe_gather u_gather (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .sample_i    (s_axis_tdata),
    .eos_i       (s_axis_tlast),
    .zig_en_i    (zig_q),
    .tail_take_i (tail_take),
    .blk_load_o  (blk_load),
    .blk_data_o  (blk_data),
    .busy_o      (busy),
    .tail_o      (tail)
  );

  bbe_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (blk_load),
    .blk_i   (blk_data),
    .take_i  (pack_take),
    .valid_o (pack_valid),
    .res_o   (pack_res)
  );

  // Raw tail item
  assign tail_res.kind  = bbe_pkg::KIND_RAW;
  assign tail_res.hdr   = '0;
  assign tail_res.low   = bbe_pkg::HALF_W'(tail.data);
  assign tail_res.high  = '0;
  assign tail_res.bytes = bbe_pkg::RAW_BYTES;
  assign tail_res.last  = tail.last;

  // Fill the result register: a pending block goes before the tail
  always_comb begin
    pack_take = 1'b0;
    tail_take = 1'b0;
    res_d     = res_q;
    out_v_d   = out_v_q;
    if (out_free) begin
      if (pack_valid) begin
        pack_take = 1'b1;
        res_d     = pack_res;
        out_v_d   = 1'b1;
      end else if (tail.valid) begin
        tail_take = 1'b1;
        res_d     = tail_res;
        out_v_d   = 1'b1;
      end else begin
        out_v_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {7'd0, res_q.bytes, res_q.high, res_q.low, res_q.hdr};

  // A packed block is always the last item of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == bbe_pkg::KIND_BLOCK)) |-> m_axis_tlast)
    else $error("packed block without last_of_run");

  // Header code and byte count agree on a packed block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == bbe_pkg::KIND_BLOCK)) |->
      ((res_q.bytes == 5'd16 && res_q.hdr == bbe_pkg::HDR_FULL) ||
       (res_q.bytes < 5'd15 && res_q.hdr == res_q.bytes[3:0])))
    else $error("header code does not match payload bytes");

  // No sample is taken while the tail drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("input ready during tail drain");

  // A waiting block survives a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pack_valid && m_axis_tvalid && !m_axis_tready) |=> pack_valid)
    else $error("pending block lost under stall");

  // A tail item never overtakes a waiting block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pack_valid |-> !tail_take)
    else $error("tail item issued ahead of a block");

endmodule
`default_nettype wire
